// ===== rtl/frasm_pkg.sv =====
package frasm_pkg;

  // Operation codes carried in the operation field.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes.
  typedef logic [2:0] status_t;
  localparam status_t ST_READ_DONE  = 3'd0;
  localparam status_t ST_STORED     = 3'd1;
  localparam status_t ST_FRAME_DONE = 3'd2;
  localparam status_t ST_SHORT      = 3'd3;
  localparam status_t ST_BAD_LENGTH = 3'd4;
  localparam status_t ST_OUT_OF_SEQ = 3'd5;
  localparam status_t ST_OVERFLOW   = 3'd6;
  localparam status_t ST_IGNORED    = 3'd7;

  // Message length limits, header included.
  localparam logic [7:0] MESSAGE_MAX  = 8'd250;
  localparam logic [7:0] HEADER_BYTES = 8'd5;

  localparam int FRAME_LENGTH_W = 12;

  // One input item as held in the input register.
  typedef struct packed {
    logic        operation;
    logic [7:0]  message_length;
    logic [15:0] fragment_length;
    logic [7:0]  fragment_index;
    logic        final_fragment;
    logic [7:0]  byte_offset;
    logic [7:0]  payload_byte;
    logic [10:0] read_index;
  } item_t;

endpackage

// ===== rtl/fragment_reassembler.sv =====
// Channel | Handshake             | Payload
// --------+-----------------------+------------------------------------------------
// in_     | in_valid / in_ready   | operation, message_length, fragment_length,
//         |                       | fragment_index, final_fragment, byte_offset,
//         |                       | payload_byte, read_index
// out_    | out_valid / out_ready | status, frame_length, frames_total, read_data
//
// Every item produces exactly one result item, loaded into the result register
// as it leaves the input register. The block sustains one item per clock while
// out_ready stays high: the input register feeds the header checks and the frame
// buffer write, and the result register parts the two sides.
// The frame buffer is a single RAM with one write and one registered read port.
// Reset is synchronous and active low; the buffer contents are not cleared.
// When the result register is full and out_ready is low, the input register
// holds its item and in_ready drops only if that register is also occupied.
module fragment_reassembler #(
  parameter int BUFFER_BYTES         = 2048,
  parameter int MAX_FRAGMENT_PAYLOAD = 245
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_message_length,
  input  logic [15:0] in_fragment_length,
  input  logic [7:0]  in_fragment_index,
  input  logic        in_final_fragment,
  input  logic [7:0]  in_byte_offset,
  input  logic [7:0]  in_payload_byte,
  input  logic [10:0] in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [11:0] out_frame_length,
  output logic [31:0] out_frames_total,
  output logic [7:0]  out_read_data
);

  import frasm_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  // Wide enough for both the 11-bit read index and the buffer size itself.
  localparam int XW = (AW > 11 ? AW : 11) + 1;

  // Input register stage.
  logic  s1_valid_r, s1_valid_nxt;
  item_t item_r;
  logic  in_fire;
  logic  s1_adv;

  // Result register stage.
  logic        out_valid_r, out_valid_nxt;
  status_t     status_r;
  logic [11:0] frame_length_r;
  logic [31:0] frames_total_r;
  logic [7:0]  read_data_r;

  // Frame buffer access.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_rdata;
  logic [XW-1:0] in_ri_ext;
  logic [XW-1:0] item_ri_ext;

  // Write bypass: the RAM returns old data for an address written at the
  // same edge the read was launched, so that write is remembered here.
  logic          byp_valid_r;
  logic [AW-1:0] byp_addr_r;
  logic [7:0]    byp_data_r;

  status_t     status;
  logic [11:0] frame_length_nxt;
  logic [31:0] frames_total_nxt;
  logic [7:0]  read_data;

  // An item can enter whenever the input register is empty or drains this cycle.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byp_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      byp_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.operation       <= in_operation;
      item_r.message_length  <= in_message_length;
      item_r.fragment_length <= in_fragment_length;
      item_r.fragment_index  <= in_fragment_index;
      item_r.final_fragment  <= in_final_fragment;
      item_r.byte_offset     <= in_byte_offset;
      item_r.payload_byte    <= in_payload_byte;
      item_r.read_index      <= in_read_index;
    end
    if (s1_adv) begin
      status_r       <= status;
      frame_length_r <= frame_length_nxt;
      frames_total_r <= frames_total_nxt;
      read_data_r    <= read_data;
    end
    byp_addr_r <= wr_addr;
    byp_data_r <= wr_data;
  end

  // The read is launched as the item is accepted, and re-launched every
  // cycle while it waits, so the data lines up with the input register.
  assign in_ri_ext   = XW'(in_read_index);
  assign item_ri_ext = XW'(item_r.read_index);
  assign rd_addr     = in_fire ? in_ri_ext[AW-1:0] : item_ri_ext[AW-1:0];

  frasm_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  frasm_ctrl #(
    .BUFFER_BYTES         (BUFFER_BYTES),
    .MAX_FRAGMENT_PAYLOAD (MAX_FRAGMENT_PAYLOAD)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (s1_adv),
    .item             (item_r),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .status           (status),
    .frame_length_nxt (frame_length_nxt),
    .frames_total_nxt (frames_total_nxt)
  );

  // A read beyond the buffer returns zero; a push returns zero as well.
  always_comb begin
    read_data = 8'd0;
    if (item_r.operation == OP_READ && item_ri_ext < XW'(BUFFER_BYTES)) begin
      if (byp_valid_r && byp_addr_r == item_ri_ext[AW-1:0]) begin
        read_data = byp_data_r;
      end else begin
        read_data = ram_rdata;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_frame_length = frame_length_r;
  assign out_frames_total = frames_total_r;
  assign out_read_data    = read_data_r;

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item did not reach the result register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  a_write_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_adv && item_r.operation == OP_PUSH))
    else $error("buffer written outside an advancing push");

endmodule

// ===== rtl/frasm_ram.sv =====
module frasm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/frasm_ctrl.sv =====
module frasm_ctrl #(
  parameter int BUFFER_BYTES         = 2048,
  parameter int MAX_FRAGMENT_PAYLOAD = 245
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  frasm_pkg::item_t                item,
  output logic                            wr_en,
  output logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
  output logic [7:0]                      wr_data,
  output frasm_pkg::status_t              status,
  output logic [11:0]                     frame_length_nxt,
  output logic [31:0]                     frames_total_nxt
);

  import frasm_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int LW = $clog2(BUFFER_BYTES + 1);
  localparam int SW = (LW > 16 ? LW : 16) + 1;

  logic [LW-1:0] asm_len_r, asm_len_nxt;
  logic [7:0]    exp_idx_r, exp_idx_nxt;
  logic          frag_acc_r, frag_acc_nxt;
  logic [11:0]   last_len_r, last_len_nxt;
  logic [31:0]   frame_cnt_r, frame_cnt_nxt;

  logic          is_push;
  logic          restart;
  logic [LW-1:0] eff_asm;
  logic [7:0]    eff_exp;
  logic [SW-1:0] hdr_sum;
  logic          go;
  logic [LW-1:0] base;
  logic [7:0]    exp_base;
  logic [SW-1:0] pos;
  logic [SW-1:0] end_sum;
  logic          last_byte;

  assign is_push   = (item.operation == OP_PUSH);
  assign restart   = (item.fragment_index == 8'd0);
  assign eff_asm   = restart ? '0 : asm_len_r;
  assign eff_exp   = restart ? 8'd0 : exp_idx_r;
  assign hdr_sum   = SW'(eff_asm) + SW'(item.fragment_length);
  assign pos       = SW'(base) + SW'(item.byte_offset);
  assign end_sum   = SW'(base) + SW'(item.fragment_length);
  assign last_byte = (17'(item.byte_offset) + 17'd1) == 17'(item.fragment_length);

  always_comb begin
    status        = ST_IGNORED;
    asm_len_nxt   = asm_len_r;
    exp_idx_nxt   = exp_idx_r;
    frag_acc_nxt  = frag_acc_r;
    last_len_nxt  = last_len_r;
    frame_cnt_nxt = frame_cnt_r;
    go            = frag_acc_r;
    base          = asm_len_r;
    exp_base      = exp_idx_r;
    wr_en         = 1'b0;

    if (item.byte_offset == 8'd0) begin
      frag_acc_nxt = 1'b0;
      go           = 1'b0;
      if (item.message_length == 8'd0 || item.message_length > MESSAGE_MAX) begin
        status = ST_IGNORED;
      end else if (item.message_length < HEADER_BYTES) begin
        status = ST_SHORT;
      end else if (item.fragment_length == 16'd0 ||
                   item.fragment_length > 16'(MAX_FRAGMENT_PAYLOAD)) begin
        status = ST_BAD_LENGTH;
      end else if (item.fragment_index != eff_exp) begin
        asm_len_nxt = '0;
        exp_idx_nxt = 8'd0;
        status      = ST_OUT_OF_SEQ;
      end else if (hdr_sum > SW'(BUFFER_BYTES)) begin
        asm_len_nxt = '0;
        exp_idx_nxt = 8'd0;
        status      = ST_OVERFLOW;
      end else begin
        go           = 1'b1;
        frag_acc_nxt = 1'b1;
        base         = eff_asm;
        exp_base     = eff_exp;
        asm_len_nxt  = eff_asm;
        exp_idx_nxt  = eff_exp;
      end
    end

    if (go) begin
      if (16'(item.byte_offset) >= item.fragment_length) begin
        status = ST_IGNORED;
      end else if (pos >= SW'(BUFFER_BYTES)) begin
        status = ST_IGNORED;
      end else begin
        wr_en = 1'b1;
        if (!last_byte) begin
          status = ST_STORED;
        end else begin
          frag_acc_nxt = 1'b0;
          if (item.final_fragment) begin
            last_len_nxt  = 12'(end_sum);
            frame_cnt_nxt = frame_cnt_r + 32'd1;
            asm_len_nxt   = '0;
            exp_idx_nxt   = 8'd0;
            status        = ST_FRAME_DONE;
          end else begin
            asm_len_nxt = LW'(end_sum);
            exp_idx_nxt = exp_base + 8'd1;
            status      = ST_STORED;
          end
        end
      end
    end

    if (!is_push) begin
      status        = ST_READ_DONE;
      wr_en         = 1'b0;
      asm_len_nxt   = asm_len_r;
      exp_idx_nxt   = exp_idx_r;
      frag_acc_nxt  = frag_acc_r;
      last_len_nxt  = last_len_r;
      frame_cnt_nxt = frame_cnt_r;
    end

    wr_en = wr_en & step;
  end

  assign wr_addr          = pos[AW-1:0];
  assign wr_data          = item.payload_byte;
  assign frame_length_nxt = last_len_nxt;
  assign frames_total_nxt = frame_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_len_r   <= '0;
      exp_idx_r   <= 8'd0;
      frag_acc_r  <= 1'b0;
      last_len_r  <= 12'd0;
      frame_cnt_r <= 32'd0;
    end else if (step) begin
      asm_len_r   <= asm_len_nxt;
      exp_idx_r   <= exp_idx_nxt;
      frag_acc_r  <= frag_acc_nxt;
      last_len_r  <= last_len_nxt;
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    (step && status == ST_FRAME_DONE) |=> frame_cnt_r == $past(frame_cnt_r) + 32'd1)
    else $error("frame counter did not advance on a completed frame");

  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (status == ST_SHORT || status == ST_BAD_LENGTH || status == ST_OUT_OF_SEQ ||
              status == ST_OVERFLOW || status == ST_FRAME_DONE)) |=> !frag_acc_r)
    else $error("fragment still accepted after a drop or frame end");

  a_asm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(asm_len_r) <= SW'(BUFFER_BYTES))
    else $error("assembly length beyond the buffer");

endmodule
